@@ rtl/ckc_pkg.sv @@
// Package for the color key centroid block: widths, limits, register codes,
// the request and result types and small helper functions.
// Used by every module in rtl; depends on nothing.
`timescale 1ns / 1ps

package ckc_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int PIX_W   = 8;
   localparam int FW_W    = 12;
   localparam int COORD_W = 11;
   localparam int COUNT_W = 23;
   localparam int SUM_W   = 34;
   localparam int STEP_W  = $clog2(SUM_W + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = FW_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_RED     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_GREEN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BLUE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH = 3'd4;

   localparam logic [PIX_W-1:0] KEY_RED_RESET     = 8'd208;
   localparam logic [PIX_W-1:0] KEY_GREEN_RESET   = 8'd138;
   localparam logic [PIX_W-1:0] KEY_BLUE_RESET    = 8'd116;
   localparam logic [PIX_W-1:0] TOLERANCE_RESET   = 8'd25;
   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET = 12'd640;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [COORD_W-1:0] COORD_MAX   = {COORD_W{1'b1}};
   localparam logic [FW_W-1:0]    WIDTH_LIMIT = FW_W'(MAX_WIDTH);
   localparam int ROW_MAX_INT = (MAX_HEIGHT - 1 > 2047) ? 2047 : MAX_HEIGHT - 1;
   localparam logic [COORD_W-1:0] ROW_MAX = COORD_W'(ROW_MAX_INT);

   typedef struct packed {
      logic               mask_bit;
      logic               last_pixel;
      logic [COUNT_W-1:0] match_count;
      logic [SUM_W-1:0]   column_sum;
      logic [SUM_W-1:0]   row_sum;
   } entry_type;

   typedef struct packed {
      logic               mask_bit;
      logic               centroid_valid;
      logic               empty_frame;
      logic [COORD_W-1:0] centroid_col;
      logic [COORD_W-1:0] centroid_row;
   } rsp_type;

   typedef enum logic {
      BACK_PASS,
      BACK_DIVIDE
   } back_state_type;

   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] q);
      return (q > SUM_W'(COORD_MAX)) ? COORD_MAX : q[COORD_W-1:0];
   endfunction

endpackage

@@ rtl/ckc_front.sv @@
// Front part: configuration registers, key match per pixel, position counters
// and the running count and sums of matching pixels.
// Depends on ckc_pkg; feeds ckc_queue.
`timescale 1ns / 1ps

module ckc_front
   import ckc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_push,
   input  logic [PIX_W-1:0]       req_red,
   input  logic [PIX_W-1:0]       req_green,
   input  logic [PIX_W-1:0]       req_blue,
   input  logic                   req_last_pixel,
   input  logic                   q_full,
   output logic                   q_push,
   output entry_type              q_entry
);

   logic [PIX_W-1:0]   key_red_ff, key_green_ff, key_blue_ff, tolerance_ff;
   logic [FW_W-1:0]    frame_width_ff;
   logic [COORD_W-1:0] column_ff, column_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   column_sum_ff, column_sum_in;
   logic [SUM_W-1:0]   row_sum_ff, row_sum_in;
   logic               match, add_match, row_end;
   logic [FW_W-1:0]    width_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_red_ff     <= KEY_RED_RESET;
         key_green_ff   <= KEY_GREEN_RESET;
         key_blue_ff    <= KEY_BLUE_RESET;
         tolerance_ff   <= TOLERANCE_RESET;
         frame_width_ff <= FRAME_WIDTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_RED:     key_red_ff     <= csr_data[PIX_W-1:0];
            CSR_KEY_GREEN:   key_green_ff   <= csr_data[PIX_W-1:0];
            CSR_KEY_BLUE:    key_blue_ff    <= csr_data[PIX_W-1:0];
            CSR_TOLERANCE:   tolerance_ff   <= csr_data[PIX_W-1:0];
            CSR_FRAME_WIDTH: frame_width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      match = (abs_diff(req_red, key_red_ff) <= tolerance_ff) &&
              (abs_diff(req_green, key_green_ff) <= tolerance_ff) &&
              (abs_diff(req_blue, key_blue_ff) <= tolerance_ff);
      add_match = match && (count_ff != COUNT_MAX);
      q_push = req_push && !q_full;

      count_in      = count_ff + COUNT_W'(add_match);
      column_sum_in = add_match ? column_sum_ff + SUM_W'(column_ff) : column_sum_ff;
      row_sum_in    = add_match ? row_sum_ff + SUM_W'(row_ff) : row_sum_ff;

      q_entry.mask_bit    = match;
      q_entry.last_pixel  = req_last_pixel;
      q_entry.match_count = count_in;
      q_entry.column_sum  = column_sum_in;
      q_entry.row_sum     = row_sum_in;

      if (frame_width_ff == '0) begin
         width_eff = FW_W'(1);
      end else if (frame_width_ff > WIDTH_LIMIT) begin
         width_eff = WIDTH_LIMIT;
      end else begin
         width_eff = frame_width_ff;
      end
      row_end = ({1'b0, column_ff} + FW_W'(1)) >= width_eff;

      if (row_end) begin
         column_in = '0;
         row_in    = (row_ff < ROW_MAX) ? row_ff + COORD_W'(1) : row_ff;
      end else begin
         column_in = column_ff + COORD_W'(1);
         row_in    = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         count_ff      <= '0;
         column_sum_ff <= '0;
         row_sum_ff    <= '0;
      end else if (q_push) begin
         if (req_last_pixel) begin
            column_ff     <= '0;
            row_ff        <= '0;
            count_ff      <= '0;
            column_sum_ff <= '0;
            row_sum_ff    <= '0;
         end else begin
            column_ff     <= column_in;
            row_ff        <= row_in;
            count_ff      <= count_in;
            column_sum_ff <= column_sum_in;
            row_sum_ff    <= row_sum_in;
         end
      end
   end

endmodule

@@ rtl/ckc_queue.sv @@
// Short queue of classified pixels between the front and back parts.
// Depends on ckc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ckc_queue
   import ckc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type din,
   output logic      full,
   input  logic      pop,
   output entry_type dout,
   output logic      empty
);

   entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   fill_ff;

   assign full  = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign dout  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         fill_ff <= fill_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
      end
   end

endmodule

@@ rtl/ckc_div.sv @@
// Restoring divider, one quotient bit per cycle, for a sum over a match count.
// Depends on ckc_pkg for the operand widths.
`timescale 1ns / 1ps

module ckc_div
   import ckc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               busy,
   output logic [SUM_W-1:0]   quotient
);

   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] div_ff;
   logic [SUM_W-1:0]   quo_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [COUNT_W:0]   trial, diff;
   logic               fits;

   assign busy     = (step_ff != '0);
   assign quotient = quo_ff;

   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         div_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (start) begin
         step_ff <= STEP_W'(SUM_W);
      end else if (busy) begin
         step_ff <= step_ff - STEP_W'(1);
      end
   end

endmodule

@@ rtl/ckc_back.sv @@
// Back part: takes classified pixels from the queue, divides the sums at the
// end of a frame and holds the result register of the response channel.
// Depends on ckc_pkg and ckc_div.
`timescale 1ns / 1ps

module ckc_back
   import ckc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  entry_type q_entry,
   output logic      q_pop,
   input  logic      rsp_pop,
   output logic      rsp_empty,
   output rsp_type   rsp
);

   back_state_type state_ff, state_in;
   logic           valid_ff, valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic           mask_ff;
   logic           out_free, load_out, div_start, div_needed;
   logic           col_busy, row_busy;
   logic [SUM_W-1:0] col_quo, row_quo;

   ckc_div u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_entry.column_sum),
      .divisor  (q_entry.match_count),
      .busy     (col_busy),
      .quotient (col_quo)
   );

   ckc_div u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_entry.row_sum),
      .divisor  (q_entry.match_count),
      .busy     (row_busy),
      .quotient (row_quo)
   );

   assign out_free   = !valid_ff || rsp_pop;
   assign div_needed = q_entry.last_pixel && (q_entry.match_count != '0);
   assign rsp_empty  = !valid_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      rsp_in    = rsp_ff;
      unique case (state_ff)
         BACK_PASS: begin
            if (!q_empty) begin
               if (div_needed) begin
                  q_pop     = 1'b1;
                  div_start = 1'b1;
                  state_in  = BACK_DIVIDE;
               end else if (out_free) begin
                  q_pop                 = 1'b1;
                  load_out              = 1'b1;
                  rsp_in.mask_bit       = q_entry.mask_bit;
                  rsp_in.centroid_valid = 1'b0;
                  rsp_in.empty_frame    = q_entry.last_pixel;
                  rsp_in.centroid_col   = '0;
                  rsp_in.centroid_row   = '0;
               end
            end
         end
         BACK_DIVIDE: begin
            if (!col_busy && !row_busy && out_free) begin
               load_out              = 1'b1;
               rsp_in.mask_bit       = mask_ff;
               rsp_in.centroid_valid = 1'b1;
               rsp_in.empty_frame    = 1'b0;
               rsp_in.centroid_col   = sat_coord(col_quo);
               rsp_in.centroid_row   = sat_coord(row_quo);
               state_in              = BACK_PASS;
            end
         end
         default: state_in = BACK_PASS;
      endcase
      valid_in = load_out || (valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_PASS;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
      if (div_start) begin
         mask_ff <= q_entry.mask_bit;
      end
   end

endmodule

@@ rtl/color_key_centroid.sv @@
// Top level of the color key centroid block: front, queue and back parts.
// Depends on ckc_pkg, ckc_front, ckc_queue, ckc_div and ckc_back.
//
// Pixels enter in raster order on the request channel: req_push with the
// three color channels and req_last_pixel, taken when req_full is low.
// Every request gives exactly one response: rsp_mask_bit tells whether the
// pixel lies within csr tolerance of the key color; on the pixel that ends a
// frame, rsp_centroid_valid with the truncated mean column and row of the
// matching pixels, or rsp_empty_frame when nothing matched. A response is
// held while rsp_empty is low and is taken with rsp_pop.
// The front takes one pixel per cycle while req_full is low. A request is
// registered in the queue, then in the result register. A frame end with
// matches goes through two serial dividers in the back; a four-entry queue
// between front and back absorbs pixels meanwhile, after which req_full
// rises until it drains. A stalled receiver fills the result register, then
// the queue, then holds req_full high. Reset clears the counters, sums, queue
// and result valid flag, and loads the default key color, tolerance and frame
// width. Configuration is written through csr_write, csr_index and csr_data
// while no request is in flight; a write to an unused index is ignored.
`timescale 1ns / 1ps

module color_key_centroid
   import ckc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [PIX_W-1:0]       req_red,
   input  logic [PIX_W-1:0]       req_green,
   input  logic [PIX_W-1:0]       req_blue,
   input  logic                   req_last_pixel,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_mask_bit,
   output logic                   rsp_centroid_valid,
   output logic                   rsp_empty_frame,
   output logic [COORD_W-1:0]     rsp_centroid_col,
   output logic [COORD_W-1:0]     rsp_centroid_row
);

   logic      q_push, q_pop, q_full, q_empty;
   entry_type q_entry_in, q_entry_out;
   rsp_type   rsp;

   ckc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_push       (req_push),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (q_entry_in)
   );

   ckc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_entry_in),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_entry_out),
      .empty (q_empty)
   );

   ckc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (q_entry_out),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign req_full           = q_full;
   assign rsp_mask_bit       = rsp.mask_bit;
   assign rsp_centroid_valid = rsp.centroid_valid;
   assign rsp_empty_frame    = rsp.empty_frame;
   assign rsp_centroid_col   = rsp.centroid_col;
   assign rsp_centroid_row   = rsp.centroid_row;

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_centroid_valid && rsp_empty_frame))
      else $error("centroid valid and empty frame both set");

   a_centroid_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_centroid_valid) |->
         (rsp_centroid_col == '0 && rsp_centroid_row == '0))
      else $error("centroid fields nonzero without a valid centroid");

endmodule
